// File: hw/rtl/mat3_inverse_defines.svh
// Assertion helpers for the matrix inverse block.
// Both expect clk and rst_n in the scope of the module that uses them.
`ifndef MAT3_INVERSE_DEFINES_SVH
`define MAT3_INVERSE_DEFINES_SVH
`ifndef ASSERT_OFF
`define M3I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define M3I_IMPLY(lbl, ante, cons, msg) \
  `M3I_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define M3I_ASSERT(lbl, prop, msg)
`define M3I_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/m3i_pkg.sv
package m3i_pkg;
  localparam int WORD          = 32;
  localparam int NELEM         = 9;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PROD_W        = 2 * WORD;
  localparam int COF_W         = PROD_W + 1;
  localparam int DET_W         = 100;
  localparam int DIV_BITS      = 2;
  localparam int DIV_STAGES    = WORD / DIV_BITS;
  localparam int IN_W          = NELEM * WORD;
  localparam int OUT_W         = (NELEM + 1) * WORD;

  // 2x2 minor of lane g is a[MIN_A]*a[MIN_B] - a[MIN_C]*a[MIN_D]; odd lanes negate
  localparam int MIN_A [NELEM] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
  localparam int MIN_B [NELEM] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
  localparam int MIN_C [NELEM] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
  localparam int MIN_D [NELEM] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
  // first-column elements that weight cofactors 0..2 in the determinant
  localparam int X_IDX [3] = '{0, 3, 6};

  localparam logic [WORD-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [WORD-1:0]   quo;
    logic              neg;
    logic              ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NELEM-1:0] lane;
    logic [WORD-1:0]       dm;
    logic [WORD-1:0]       det_bits;
  } div_pay_t;
endpackage

// File: hw/rtl/m3i_div_stage.sv
module m3i_div_stage #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  logic               v_in,
  input  m3i_pkg::div_pay_t  pay_in,
  output logic               v_out,
  output m3i_pkg::div_pay_t  pay_out
);
  logic              v_r;
  m3i_pkg::div_pay_t pay_r;
  m3i_pkg::div_pay_t pay_nxt;

  // restoring division, two quotient bits per stage, all lanes side by side
  always_comb begin
    logic [m3i_pkg::PROD_W-1:0] dsh;
    pay_nxt = pay_in;
    for (int l = 0; l < m3i_pkg::NELEM; l++) begin
      for (int j = 0; j < m3i_pkg::DIV_BITS; j++) begin
        dsh = {{m3i_pkg::WORD{1'b0}}, pay_in.dm}
              << (m3i_pkg::WORD - 1 - m3i_pkg::DIV_BITS * STAGE - j);
        if (pay_nxt.lane[l].rem >= dsh) begin
          pay_nxt.lane[l].rem = pay_nxt.lane[l].rem - dsh;
          pay_nxt.lane[l].quo = {pay_nxt.lane[l].quo[m3i_pkg::WORD-2:0], 1'b1};
        end else begin
          pay_nxt.lane[l].quo = {pay_nxt.lane[l].quo[m3i_pkg::WORD-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      pay_r <= pay_nxt;
    end
  end

  assign v_out   = v_r;
  assign pay_out = pay_r;
endmodule

// File: hw/rtl/mat3_inverse.sv
// channel | direction | fields
// in_     | slave     | a_ix .. a_kz, 9 x 32-bit signed in tdata
// out_    | master    | r_ix .. r_kz, det_value in tdata; singular in tuser
//
// One matrix enters per cycle while in_tready is high; out_tvalid rises when it reaches the output register.
// Stages: input, products, cofactors, determinant partials, determinant sum,
// magnitudes, rounding, divisor select, divider setup, 16 divider stages of
// two quotient bits each, and the output register.
// Each stage holds while the one after it is full and stalled; empty stages fill.
// Reset clears only the stage valid bits.
`include "mat3_inverse_defines.svh"
module mat3_inverse #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // a_ix, a_iy, a_iz, a_jx, a_jy, a_jz, a_kx, a_ky, a_kz (32 bits each)
  input  logic [m3i_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // r_ix, r_iy, r_iz, r_jx, r_jy, r_jz, r_kx, r_ky, r_kz, det_value (32 bits each)
  output logic [m3i_pkg::OUT_W-1:0]  out_tdata,
  // singular
  output logic [0:0]                 out_tuser
);
  localparam int W   = m3i_pkg::WORD;
  localparam int NE  = m3i_pkg::NELEM;
  localparam int PW  = m3i_pkg::PROD_W;
  localparam int CW  = m3i_pkg::COF_W;
  localparam int DW  = m3i_pkg::DET_W;
  localparam int NDS = m3i_pkg::DIV_STAGES;
  localparam int NFR = 9;
  localparam int NST = NFR + NDS + 1;

  logic [NST-1:0] vld;
  logic [NST-1:0] ld;
  logic [NFR-1:0] v_r;

  logic signed [W-1:0]  a_r    [NE];
  logic signed [PW-1:0] p_r    [NE];
  logic signed [PW-1:0] q_r    [NE];
  logic signed [W-1:0]  x1_r   [3];
  logic signed [CW-1:0] cof2_r [NE];
  logic signed [W-1:0]  x2_r   [3];
  logic signed [CW-1:0] pl_r   [3];
  logic signed [CW-1:0] ph_r   [3];
  logic signed [CW-1:0] cof3_r [NE];
  logic signed [DW-1:0] det4_r;
  logic signed [CW-1:0] cof4_r [NE];
  logic [DW-1:0]        dmag5_r;
  logic                 dneg5_r;
  logic [PW-1:0]        cmag5_r [NE];
  logic [NE-1:0]        cneg5_r;
  logic [W-2:0]         q31_6_r;
  logic                 dovf6_r;
  logic                 dneg6_r;
  logic [PW-1:0]        cmag6_r [NE];
  logic [NE-1:0]        cneg6_r;
  logic [W-1:0]         det7_r;
  logic [W-1:0]         dm7_r;
  logic [NE-1:0]        lneg7_r;
  logic [PW-1:0]        cmag7_r [NE];
  m3i_pkg::div_pay_t    div0_r;
  logic                 out_v_r;
  logic [m3i_pkg::OUT_W-1:0] out_data_r;
  logic                 out_user_r;

  logic signed [DW-1:0] det4_nxt;
  logic [DW-1:0]        dmag5_nxt;
  logic [PW-1:0]        cmag5_nxt [NE];
  logic [W-2:0]         q31_6_nxt;
  logic                 dovf6_nxt;
  logic [W-1:0]         det7_nxt;
  logic [W-1:0]         dm7_nxt;
  logic [NE-1:0]        lneg7_nxt;
  m3i_pkg::div_pay_t    div0_nxt;
  logic [m3i_pkg::OUT_W-1:0] out_data_nxt;

  logic              dv_c [NDS+1];
  m3i_pkg::div_pay_t dp_c [NDS+1];
  logic              rem_ok_c;
  logic              det_zero_c;

  // advance a stage when it is empty or its successor advances
  genvar gi;
  generate
    for (gi = 0; gi < NST - 1; gi++) begin : g_ld
      assign ld[gi] = !vld[gi] || ld[gi+1];
    end
  endgenerate
  assign ld[NST-1] = !vld[NST-1] || out_tready;

  assign vld[NFR-1:0] = v_r;
  generate
    for (gi = 0; gi < NDS; gi++) begin : g_vld
      assign vld[NFR+gi] = dv_c[gi+1];
    end
  endgenerate
  assign vld[NST-1] = out_v_r;

  assign in_tready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NFR; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    det4_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      det4_nxt = det4_nxt + $signed({ph_r[k], {W{1'b0}}}) + pl_r[k];
    end
  end

  always_comb begin
    logic [CW-1:0] t;
    dmag5_nxt = det4_r[DW-1] ? DW'(-det4_r) : DW'(det4_r);
    for (int g = 0; g < NE; g++) begin
      t = cof4_r[g][CW-1] ? CW'(-cof4_r[g]) : CW'(cof4_r[g]);
      cmag5_nxt[g] = t[PW-1:0];
    end
  end

  always_comb begin
    logic [DW-1:0] rnd;
    logic [DW-1:0] qf;
    rnd = dmag5_r + (DW'(1) << (2 * FRAC_BITS - 1));
    qf  = rnd >> (2 * FRAC_BITS);
    q31_6_nxt = qf[W-2:0];
    dovf6_nxt = |qf[DW-1:W-1];
  end

  always_comb begin
    logic          zero;
    logic          dn;
    logic [W-1:0]  mag32;
    logic [W-1:0]  satv;
    zero  = !dovf6_r && (q31_6_r == '0);
    dn    = dneg6_r && !zero;
    satv  = dneg6_r ? m3i_pkg::SAT_MIN : m3i_pkg::SAT_MAX;
    mag32 = dovf6_r ? satv : {1'b0, q31_6_r};
    det7_nxt = dovf6_r ? satv : (dneg6_r ? W'(-{1'b0, q31_6_r}) : {1'b0, q31_6_r});
    // a zero determinant divides by one, which rounds the cofactors to the output format
    dm7_nxt   = zero ? (W'(1) << FRAC_BITS) : mag32;
    lneg7_nxt = cneg6_r ^ {NE{dn}};
  end

  always_comb begin
    div0_nxt.dm       = dm7_r;
    div0_nxt.det_bits = det7_r;
    for (int g = 0; g < NE; g++) begin
      div0_nxt.lane[g].rem = cmag7_r[g];
      div0_nxt.lane[g].quo = '0;
      div0_nxt.lane[g].neg = lneg7_r[g];
      // a quotient of 2^32 or more saturates anyway
      div0_nxt.lane[g].ovf = cmag7_r[g][PW-1:W] >= dm7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int g = 0; g < NE; g++) begin
        a_r[g] <= $signed(in_tdata[g*W +: W]);
      end
    end
    if (ld[1]) begin
      for (int g = 0; g < NE; g++) begin
        p_r[g] <= a_r[m3i_pkg::MIN_A[g]] * a_r[m3i_pkg::MIN_B[g]];
        q_r[g] <= a_r[m3i_pkg::MIN_C[g]] * a_r[m3i_pkg::MIN_D[g]];
      end
      for (int k = 0; k < 3; k++) begin
        x1_r[k] <= a_r[m3i_pkg::X_IDX[k]];
      end
    end
    if (ld[2]) begin
      for (int g = 0; g < NE; g++) begin
        if (g % 2 == 1) begin
          cof2_r[g] <= CW'(q_r[g]) - CW'(p_r[g]);
        end else begin
          cof2_r[g] <= CW'(p_r[g]) - CW'(q_r[g]);
        end
      end
      x2_r <= x1_r;
    end
    if (ld[3]) begin
      // split each 65-bit cofactor into a low unsigned and a high signed half
      for (int k = 0; k < 3; k++) begin
        pl_r[k] <= x2_r[k] * $signed({1'b0, cof2_r[k][W-1:0]});
        ph_r[k] <= x2_r[k] * $signed(cof2_r[k][CW-1:W]);
      end
      cof3_r <= cof2_r;
    end
    if (ld[4]) begin
      det4_r <= det4_nxt;
      cof4_r <= cof3_r;
    end
    if (ld[5]) begin
      dmag5_r <= dmag5_nxt;
      dneg5_r <= det4_r[DW-1];
      cmag5_r <= cmag5_nxt;
      for (int g = 0; g < NE; g++) begin
        cneg5_r[g] <= cof4_r[g][CW-1];
      end
    end
    if (ld[6]) begin
      q31_6_r <= q31_6_nxt;
      dovf6_r <= dovf6_nxt;
      dneg6_r <= dneg5_r;
      cmag6_r <= cmag5_r;
      cneg6_r <= cneg5_r;
    end
    if (ld[7]) begin
      det7_r  <= det7_nxt;
      dm7_r   <= dm7_nxt;
      lneg7_r <= lneg7_nxt;
      cmag7_r <= cmag6_r;
    end
    if (ld[8]) begin
      div0_r <= div0_nxt;
    end
  end

  assign dv_c[0] = v_r[NFR-1];
  assign dp_c[0] = div0_r;

  generate
    for (gi = 0; gi < NDS; gi++) begin : g_div
      m3i_div_stage #(
        .STAGE(gi)
      ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (ld[NFR+gi]),
        .v_in   (dv_c[gi]),
        .pay_in (dp_c[gi]),
        .v_out  (dv_c[gi+1]),
        .pay_out(dp_c[gi+1])
      );
    end
  endgenerate

  // round half away from zero on the remainder, then saturate
  always_comb begin
    m3i_pkg::div_lane_t ln;
    logic [PW:0]   rem2;
    logic          rup;
    logic [W:0]    q33;
    logic          sat;
    out_data_nxt = '0;
    for (int g = 0; g < NE; g++) begin
      ln   = dp_c[NDS].lane[g];
      rem2 = {ln.rem, 1'b0};
      rup  = rem2 >= (PW + 1)'(dp_c[NDS].dm);
      q33  = {1'b0, ln.quo} + (W + 1)'(rup);
      sat  = ln.ovf || (q33[W:W-1] != 2'b00);
      if (sat) begin
        out_data_nxt[g*W +: W] = ln.neg ? m3i_pkg::SAT_MIN : m3i_pkg::SAT_MAX;
      end else begin
        out_data_nxt[g*W +: W] = ln.neg ? W'(-q33[W-1:0]) : q33[W-1:0];
      end
    end
    out_data_nxt[NE*W +: W] = dp_c[NDS].det_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld[NST-1]) begin
      out_v_r <= dv_c[NDS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NST-1]) begin
      out_data_r <= out_data_nxt;
      out_user_r <= dp_c[NDS].det_bits == '0;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

  assign rem_ok_c   = dp_c[NDS].lane[0].ovf || (dp_c[NDS].lane[0].rem < PW'(dp_c[NDS].dm));
  assign det_zero_c = out_tdata[NE*W +: W] == '0;

  `M3I_IMPLY(a_full_when_blocked, !in_tready, v_r[0], "input stalled with empty first stage")
  `M3I_IMPLY(a_divisor_nonzero, v_r[7], dm7_r != '0, "zero divisor entered divider")
  `M3I_IMPLY(a_rem_bound, dv_c[NDS], rem_ok_c, "divider remainder not below divisor")
  `M3I_IMPLY(a_singular_det, out_tvalid && out_tuser[0], det_zero_c, "singular with nonzero det")
endmodule
